// File: design/ted_pkg.sv
// ted_pkg: shared constants and types for the tempo envelope ducker.
// No dependencies.
package ted_pkg;
  localparam logic [1:0] FUNC_FRAME = 2'd0;
  localparam logic [1:0] FUNC_TWRITE = 2'd1;
  localparam logic [1:0] FUNC_SYNC = 2'd2;
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  localparam logic [1:0] CFG_TRIGGER = 2'd0;
  localparam logic [1:0] CFG_MIX = 2'd1;
  localparam logic [1:0] CFG_STEP = 2'd2;
  localparam logic [1:0] CFG_COEF = 2'd3;

  localparam logic [16:0] UNITY_Q15 = 17'd32768;

  // Serial multiplier control.
  typedef struct packed {
    logic start;
    logic busy;
  } mul_ctl_t;
endpackage

// File: design/tempo_envelope_ducker.sv
// tempo_envelope_ducker: stereo LFO gain ducker with one-pole smoothing.
// A frame passes two table reads, six serial products and one output load; input
// is taken only in idle, after the last frame. A result held by out_ready stalls
// the next frame at its output load. Table writes and sync loads pass through a
// wait state before returning to idle.
// Reset (synchronous, rst_n low) restores configuration, control registers and state; table contents
// stay undefined until written.
module tempo_envelope_ducker #(
  parameter int TABLE_DEPTH = 1024,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [31:0]             cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_func,
  input  logic signed [SAMPLE_BITS-1:0] in_left_in,
  input  logic signed [SAMPLE_BITS-1:0] in_right_in,
  input  logic                    in_note_on,
  input  logic [9:0]              in_entry_index,
  input  logic [15:0]             in_entry_value,
  input  logic [31:0]             in_sync_phase,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_left_out,
  output logic signed [SAMPLE_BITS-1:0] out_right_out,
  output logic [15:0]             out_gain_now,
  output logic                    out_envelope_running
);
  import ted_pkg::*;

  localparam int TAW = $clog2(TABLE_DEPTH);
  localparam int AW = (SAMPLE_BITS + 16 > 40) ? SAMPLE_BITS + 16 : 40;
  localparam int PW = AW + 17;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDA = 4'd1;
  localparam logic [3:0] S_RDB = 4'd2;
  localparam logic [3:0] S_M1 = 4'd3;
  localparam logic [3:0] S_M2 = 4'd4;
  localparam logic [3:0] S_M3 = 4'd5;
  localparam logic [3:0] S_M4 = 4'd6;
  localparam logic [3:0] S_M5 = 4'd7;
  localparam logic [3:0] S_M6 = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;
  localparam logic [3:0] S_RDW = 4'd10;

  // Configuration registers.
  logic        trig_r;
  logic [15:0] mix_r;
  logic [31:0] step_r;
  logic [15:0] coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_r <= 1'b0;
      mix_r <= 16'd32768;
      step_r <= '0;
      coef_r <= 16'd60000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TRIGGER: trig_r <= cfg_data[0];
        CFG_MIX:     mix_r <= cfg_data[15:0];
        CFG_STEP:    step_r <= cfg_data;
        CFG_COEF:    coef_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Envelope table memory.
  logic [15:0] tbl_mem [TABLE_DEPTH];
  logic [15:0] tbl_q_r;
  logic        tbl_we;
  logic [TAW-1:0] tbl_waddr, tbl_raddr;
  logic [15:0] tbl_wdata;
  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
    tbl_q_r <= tbl_mem[tbl_raddr];
  end

  logic [3:0]  st_r, st_nxt;
  logic [31:0] phase_r, phase_nxt;
  logic        run_r, run_nxt;
  logic [31:0] sg_r, sg_nxt;
  logic [SAMPLE_BITS-1:0] li_r, ri_r;
  logic        note_r;
  logic [TAW-1:0] idx_r;
  logic [15:0] frac_r;
  logic [15:0] ea_r, ea_nxt;
  logic [15:0] shape_r, shape_nxt;
  logic [16:0] tgt_r, tgt_nxt;
  logic [15:0] gq_r, gq_nxt;
  logic [AW-1:0] t_r, t_nxt;
  logic        sg_ge_r, sg_ge_nxt;
  logic        lneg_r, lneg_nxt, rneg_r, rneg_nxt;
  logic        ovld_r, ovld_nxt;
  logic [SAMPLE_BITS-1:0] lo_r, lo_nxt, ro_r, ro_nxt;
  logic [SAMPLE_BITS-1:0] olo_r, olo_nxt, oro_r, oro_nxt;
  logic        orun_r, orun_nxt;
  logic [15:0] ogain_r, ogain_nxt;

  logic          mstart;
  logic [AW-1:0] ma;
  logic [16:0]   mb;
  mul_ctl_t      mctl;
  logic [PW-1:0] mprod;

  ted_sermul #(.AW(AW), .BW(17)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mstart), .a(ma), .b(mb),
    .ctl(mctl), .prod(mprod)
  );

  wire in_acc = in_valid && in_ready;
  wire out_acc = ovld_r && out_ready;
  assign in_ready = (st_r == S_IDLE);

  // Signed magnitude and saturation helpers.
  function automatic logic [SAMPLE_BITS-1:0] mag(input logic [SAMPLE_BITS-1:0] x);
    mag = x[SAMPLE_BITS-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] satq(input logic [PW-1:0] p,
                                                  input logic neg);
    logic [PW-1:0] mx;
    logic [PW-1:0] q;
    mx = PW'((64'd1 << (SAMPLE_BITS - 1)) - 1);
    // Round half up in signed sense: pos -> +16384, neg -> +16383 on the magnitude.
    q = neg ? ((p + PW'(16383)) >> 15) : ((p + PW'(16384)) >> 15);
    if (!neg) begin
      satq = (q > mx) ? mx[SAMPLE_BITS-1:0] : q[SAMPLE_BITS-1:0];
    end else begin
      satq = (q > mx + 1) ? ~mx[SAMPLE_BITS-1:0] :
             (~q[SAMPLE_BITS-1:0] + 1'b1);
    end
  endfunction

  logic [16:0] mixc;
  assign mixc = (17'(mix_r) > UNITY_Q15) ? UNITY_Q15 : 17'(mix_r);

  logic [32:0] psum;
  logic [31:0] ppos_hi;
  assign psum = {1'b0, phase_r} + {1'b0, step_r};

  // Sequencer: table writes and sync loads, or frame entry reads, serial products and output load.
  always_comb begin
    logic [15:0] ev;
    logic [42+TAW:0] pos;
    logic [31:0] tq;
    logic [31:0] d;
    st_nxt = st_r;
    phase_nxt = phase_r;
    run_nxt = run_r;
    sg_nxt = sg_r;
    ea_nxt = ea_r;
    shape_nxt = shape_r;
    tgt_nxt = tgt_r;
    gq_nxt = gq_r;
    t_nxt = t_r;
    sg_ge_nxt = sg_ge_r;
    lneg_nxt = lneg_r;
    rneg_nxt = rneg_r;
    ovld_nxt = ovld_r;
    lo_nxt = lo_r;
    ro_nxt = ro_r;
    olo_nxt = olo_r;
    oro_nxt = oro_r;
    orun_nxt = orun_r;
    ogain_nxt = ogain_r;
    mstart = 1'b0;
    ma = '0;
    mb = '0;
    tbl_we = 1'b0;
    ev = (in_entry_value > 16'd32768) ? 16'd32768 : in_entry_value;
    tbl_wdata = ev;
    tbl_waddr = TAW'(in_entry_index);
    tbl_raddr = idx_r;
    pos = '0;
    tq = '0;
    d = '0;
    ppos_hi = '0;
    if (out_acc) ovld_nxt = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_func)
            FUNC_TWRITE: begin
              tbl_we = (32'(in_entry_index) < 32'(TABLE_DEPTH));
              st_nxt = S_RDW;
            end
            FUNC_SYNC: begin
              if (!trig_r) phase_nxt = in_sync_phase;
              st_nxt = S_RDW;
            end
            FUNC_FRAME: st_nxt = S_RDA;
            default: st_nxt = S_RDW;
          endcase
        end
      end
      S_RDW: st_nxt = S_IDLE;
      S_RDA: begin
        // address of entry b; note-on restart was applied at frame capture
        tbl_raddr = (idx_r == TAW'(TABLE_DEPTH - 1)) ? '0 : idx_r + 1'b1;
        st_nxt = S_RDB;
      end
      S_RDB: begin
        ea_nxt = tbl_q_r;
        // lerp: b*frac first, entry a is read back meanwhile
        mstart = 1'b1;
        ma = AW'(tbl_q_r);
        mb = 17'(frac_r);
        st_nxt = S_M1;
      end
      S_M1: begin
        if (!mctl.busy) begin
          t_nxt = mprod[AW-1:0];
          mstart = 1'b1;
          ma = AW'(tbl_q_r);
          mb = 17'h10000 - 17'(frac_r);
          st_nxt = S_M2;
        end
      end
      S_M2: begin
        if (!mctl.busy) begin
          pos = (43+TAW)'(t_r) + (43+TAW)'(mprod[AW-1:0]);
          if (trig_r && !(note_r || run_r)) shape_nxt = 16'd32768;
          else shape_nxt = pos[31:16];
          mstart = 1'b1;
          ma = AW'(mixc);
          mb = 17'(UNITY_Q15 - ((trig_r && !(note_r || run_r)) ? UNITY_Q15 :
                               17'(pos[32:16])));
          st_nxt = S_M3;
        end
      end
      S_M3: begin
        if (!mctl.busy) begin
          tgt_nxt = UNITY_Q15 - 17'((mprod + PW'(16384)) >> 15);
          tq = {tgt_nxt[15:0], 16'd0};
          if (tgt_nxt[16]) tq = 32'h80000000;
          sg_ge_nxt = sg_r >= tq;
          d = (sg_r >= tq) ? sg_r - tq : tq - sg_r;
          mstart = 1'b1;
          ma = AW'(d);
          mb = 17'(coef_r);
          // phase update
          if (trig_r) begin
            if (note_r) begin
              run_nxt = 1'b1;
            end
            if (note_r || run_r) begin
              ppos_hi = note_r ? step_r : psum[31:0];
              if (note_r ? 1'b0 : psum[32]) begin
                phase_nxt = '0;
                run_nxt = 1'b0;
              end else begin
                phase_nxt = ppos_hi;
              end
            end
          end else begin
            phase_nxt = psum[31:0];
          end
          st_nxt = S_M4;
        end
      end
      S_M4: begin
        if (!mctl.busy) begin
          tq = tgt_r[16] ? 32'h80000000 : {tgt_r[15:0], 16'd0};
          sg_nxt = sg_ge_r ? tq + 32'(mprod >> 16) : tq - 32'(mprod >> 16);
          gq_nxt = 16'((33'(sg_nxt) + 33'd32768) >> 16);
          lneg_nxt = li_r[SAMPLE_BITS-1];
          mstart = 1'b1;
          ma = AW'(mag(li_r));
          mb = 17'((33'(sg_nxt) + 33'd32768) >> 16);
          st_nxt = S_M5;
        end
      end
      S_M5: begin
        if (!mctl.busy) begin
          lo_nxt = satq(mprod, lneg_r);
          rneg_nxt = ri_r[SAMPLE_BITS-1];
          mstart = 1'b1;
          ma = AW'(mag(ri_r));
          mb = 17'((33'(sg_r) + 33'd32768) >> 16);
          st_nxt = S_M6;
        end
      end
      S_M6: begin
        if (!mctl.busy) begin
          ro_nxt = satq(mprod, rneg_r);
          st_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // Load the output register once the previous result has left
        if (!ovld_r || out_ready) begin
          ovld_nxt = 1'b1;
          olo_nxt = lo_r;
          oro_nxt = ro_r;
          ogain_nxt = gq_r;
          orun_nxt = !trig_r || run_r;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // Frame capture: restart phase on note-on in note mode before lookup.
  logic [31:0] lk_phase;
  logic [31+TAW:0] lk_pos;
  assign lk_phase = (trig_r && in_note_on) ? 32'd0 : phase_r;
  assign lk_pos = (32+TAW)'(lk_phase) * (32+TAW)'(TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      phase_r <= '0;
      run_r <= 1'b0;
      sg_r <= 32'h80000000;
      ovld_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      phase_r <= phase_nxt;
      run_r <= run_nxt;
      sg_r <= sg_nxt;
      ovld_r <= ovld_nxt;
    end
    if (in_acc) begin
      li_r <= in_left_in;
      ri_r <= in_right_in;
      note_r <= trig_r && in_note_on;
      idx_r <= lk_pos[31+TAW:32];
      frac_r <= lk_pos[31:16];
    end
    ea_r <= ea_nxt;
    shape_r <= shape_nxt;
    tgt_r <= tgt_nxt;
    gq_r <= gq_nxt;
    t_r <= t_nxt;
    sg_ge_r <= sg_ge_nxt;
    lneg_r <= lneg_nxt;
    rneg_r <= rneg_nxt;
    lo_r <= lo_nxt;
    ro_r <= ro_nxt;
    olo_r <= olo_nxt;
    oro_r <= oro_nxt;
    orun_r <= orun_nxt;
    ogain_r <= ogain_nxt;
  end

  assign out_valid = ovld_r;
  assign out_left_out = olo_r;
  assign out_right_out = oro_r;
  assign out_gain_now = ogain_r;
  assign out_envelope_running = orun_r;

  // Checks on the sequencer and output register.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !in_ready)
    else $error("input accepted while busy");
  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_gain_now <= 16'd32768))
    else $error("gain above unity");
  a_done_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DONE) |=> out_valid)
    else $error("result lost");
endmodule

// File: design/ted_sermul.sv
// ted_sermul: bit-serial unsigned multiplier, one multiplier bit per cycle.
// Depends on ted_pkg.
module ted_sermul #(
  parameter int AW = 40,
  parameter int BW = 17
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [AW-1:0]        a,
  input  logic [BW-1:0]        b,
  output ted_pkg::mul_ctl_t    ctl,
  output logic [AW+BW-1:0]     prod
);
  import ted_pkg::*;
  localparam int CW = $clog2(BW + 1);
  logic [AW+BW-1:0] acc_r, acc_nxt;
  logic [AW+BW-1:0] mc_r, mc_nxt;
  logic [BW-1:0] mb_r, mb_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // Shift and add one bit per cycle.
  always_comb begin
    acc_nxt = acc_r;
    mc_nxt = mc_r;
    mb_nxt = mb_r;
    cnt_nxt = cnt_r;
    if (start) begin
      acc_nxt = '0;
      mc_nxt = {{BW{1'b0}}, a};
      mb_nxt = b;
      cnt_nxt = CW'(BW);
    end else if (cnt_r != '0) begin
      if (mb_r[0]) acc_nxt = acc_r + mc_r;
      mc_nxt = mc_r << 1;
      mb_nxt = mb_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    mc_r <= mc_nxt;
    mb_r <= mb_nxt;
  end

  assign ctl.start = start;
  assign ctl.busy = (cnt_r != '0);
  assign prod = acc_r;
endmodule
